/* hdl/ile_pkg.sv */
`default_nettype none

package ile_pkg;

  // Payload widths of the two stream channels.
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 8;
  localparam int unsigned ReqW     = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned EntCntW  = 9;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // Request kinds carried in the slave-side tuser.
  typedef enum logic [ReqW-1:0] {
    REQ_GET         = 3'd0,
    REQ_INSERT_HEAD = 3'd1,
    REQ_INSERT_TAIL = 3'd2,
    REQ_INSERT_AT   = 3'd3,
    REQ_DELETE_AT   = 3'd4
  } req_e;

  // Completion codes carried in the master-side tuser.
  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GET_RD,
    S_GET_DATA,
    S_INS_RD,
    S_INS_WR,
    S_INS_NEW,
    S_DEL_RD,
    S_DEL_WR
  } seq_state_e;

  typedef enum logic {
    PH_RUN,
    PH_DONE
  } phase_e;

endpackage

`default_nettype wire

/* hdl/indexed_list_engine_core.sv */
// Indexed list engine: an ordered list of signed 32-bit values with a count.
// Requests arrive on the slave stream (s_axis_*), one result per request
// leaves on the master stream (m_axis_*). A request kind is one of get,
// insert at head, insert at tail, insert at position or delete at position.
// The list lives in a single-port-write, registered-read memory; inserts and
// deletes move the later entries one at a time through that memory, each
// moved entry being read and then written. An insert or delete moves at most
// CAPACITY-1 entries; a rejected request or an unused kind gives its result
// without touching the memory. The block takes one request at a time:
// s_axis_tready is high only while the sequencer is idle and no result waits
// to be loaded, so the next request can be accepted while the previous result
// is presented, and each request occupies the block until its result is
// loaded into the output register.
// Results sit in an output register; while the receiver stalls a finished
// result is held there and the sequencer waits before loading the next one.
// Reset empties the list at once (the count is cleared; the contents are
// not swept) and drops any result that has not been taken.
`default_nettype none

module indexed_list_engine_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // position [7:0], item_value [39:8]
  input  wire logic [ile_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type [2:0]
  input  wire logic [ile_pkg::ReqW-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // read_value [31:0], entry_count [40:32], zero fill [47:41]
  output logic      [ile_pkg::OutDataW-1:0]  m_axis_tdata,
  // status [1:0]
  output logic      [ile_pkg::StatusW-1:0]   m_axis_tuser
);

  import ile_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  seq_state_e        state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     tgt_q, tgt_d;
  logic [DataW-1:0]  value_q, value_d;
  logic [DataW-1:0]  res_value_q, res_value_d;
  status_e           res_status_q, res_status_d;

  logic                  m_valid_q, m_valid_d;
  logic [OutDataW-1:0]   m_data_q, m_data_d;
  logic [StatusW-1:0]    m_user_q, m_user_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [DataW-1:0] ram_rdata;

  logic [EntCntW-1:0] pos9, cnt9, tgt9;
  logic [CW-1:0]      idx_dec, idx_inc;
  logic               in_hs, out_free;
  req_e               req;

  ile_ram #(
    .Depth (CAPACITY),
    .AddrW (AW),
    .DataW (DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request decode helpers.
  assign req      = req_e'(s_axis_tuser);
  assign pos9     = {1'b0, s_axis_tdata[PosW-1:0]};
  assign cnt9     = EntCntW'(count_q);
  assign idx_dec  = idx_q - CW'(1);
  assign idx_inc  = idx_q + CW'(1);
  assign in_hs    = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_valid_q | m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE) && (phase_q == PH_RUN);

  // Insert target position by request kind.
  always_comb begin
    unique case (req)
      REQ_INSERT_HEAD: tgt9 = '0;
      REQ_INSERT_TAIL: tgt9 = cnt9;
      default:         tgt9 = pos9;
    endcase
  end

  // Sequencer: next state, memory port and result.
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    count_d      = count_q;
    idx_d        = idx_q;
    tgt_d        = tgt_q;
    value_d      = value_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q & ~m_axis_tready;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_dec[AW-1:0];

    if (phase_q == PH_DONE) begin
      // Hand the finished result to the output register once it is free.
      if (out_free) begin
        m_valid_d = 1'b1;
        m_data_d  = {(OutDataW - DataW - EntCntW)'(0), cnt9, res_value_q};
        m_user_d  = res_status_q;
        phase_d   = PH_RUN;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_hs) begin
            value_d      = s_axis_tdata[PosW +: DataW];
            res_value_d  = '0;
            res_status_d = ST_DONE;
            phase_d      = PH_DONE;
            unique case (req)
              REQ_GET: begin
                if (pos9 < cnt9) begin
                  tgt_d   = CW'(pos9);
                  phase_d = PH_RUN;
                  state_d = S_GET_RD;
                end else begin
                  res_value_d  = '1;
                  res_status_d = ST_RANGE;
                end
              end
              REQ_INSERT_HEAD, REQ_INSERT_TAIL, REQ_INSERT_AT: begin
                if (tgt9 > cnt9) begin
                  res_status_d = ST_RANGE;
                end else if (cnt9 >= EntCntW'(CAPACITY)) begin
                  res_status_d = ST_FULL;
                end else begin
                  tgt_d   = CW'(tgt9);
                  idx_d   = count_q;
                  phase_d = PH_RUN;
                  state_d = S_INS_RD;
                end
              end
              REQ_DELETE_AT: begin
                if (pos9 >= cnt9) begin
                  res_status_d = ST_RANGE;
                end else begin
                  idx_d   = CW'(pos9);
                  phase_d = PH_RUN;
                  state_d = S_DEL_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_GET_RD: begin
          ram_raddr = tgt_q[AW-1:0];
          state_d   = S_GET_DATA;
        end
        S_GET_DATA: begin
          res_value_d = ram_rdata;
          phase_d     = PH_DONE;
          state_d     = S_IDLE;
        end
        // Move entries up from the tail down to the gap.
        S_INS_RD: begin
          if (idx_q == tgt_q) begin
            state_d = S_INS_NEW;
          end else begin
            state_d = S_INS_WR;
          end
        end
        S_INS_WR: begin
          ram_we  = 1'b1;
          idx_d   = idx_dec;
          state_d = S_INS_RD;
        end
        S_INS_NEW: begin
          ram_we    = 1'b1;
          ram_waddr = tgt_q[AW-1:0];
          ram_wdata = value_q;
          count_d   = count_q + CW'(1);
          phase_d   = PH_DONE;
          state_d   = S_IDLE;
        end
        // Move entries down from above the gap to the tail.
        S_DEL_RD: begin
          ram_raddr = idx_inc[AW-1:0];
          if (idx_inc == count_q) begin
            count_d = count_q - CW'(1);
            phase_d = PH_DONE;
            state_d = S_IDLE;
          end else begin
            state_d = S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          ram_we  = 1'b1;
          idx_d   = idx_inc;
          state_d = S_DEL_RD;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_RUN;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    tgt_q        <= tgt_d;
    value_q      <= value_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef NO_ASSERTIONS
  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt9 <= EntCntW'(CAPACITY))
    else $error("entry count above capacity");

  // The memory is written only while an insert or delete is at work.
  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INS_WR || state_q == S_INS_NEW || state_q == S_DEL_WR))
    else $error("memory write outside an insert or delete");

  // A full status is reported only with a full list.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_FULL) |->
      (m_axis_tdata[DataW +: EntCntW] == EntCntW'(CAPACITY)))
    else $error("full status with a list that is not full");

  // The count moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
    else $error("entry count jumped");
`endif

endmodule

`default_nettype wire

/* hdl/ile_ram.sv */
`default_nettype none

module ile_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* tb/sv/tb_indexed_list_engine_core.sv */
`timescale 1ns / 1ps

module tb_indexed_list_engine_core;
  import ile_pkg::*;

  localparam int unsigned ListCap   = 64;
  localparam int unsigned NumItems  = 1850;
  localparam int unsigned NumPhases = 4;
  localparam int unsigned DrainWait = 200;

  // Request codes with no defined operation; the block must leave the list alone.
  localparam logic [ReqW-1:0] ReqSpare5 = 3'd5;
  localparam logic [ReqW-1:0] ReqSpare6 = 3'd6;
  localparam logic [ReqW-1:0] ReqSpare7 = 3'd7;

  // Value patterns used at the edges of the signed range.
  localparam logic [DataW-1:0] ValMaxPos = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] ValMinNeg = 32'h8000_0000;
  localparam logic [DataW-1:0] ValAllOne = 32'hFFFF_FFFF;

  // Moods of the random part: grow the list, shrink it, or mix.
  typedef enum int {
    MOOD_FILL,
    MOOD_DRAIN,
    MOOD_MIXED
  } mood_e;

  typedef struct packed {
    logic [DataW-1:0]   rd_val;
    logic [StatusW-1:0] status;
    logic [EntCntW-1:0] count;
  } list_result_t;

  typedef struct packed {
    logic [ReqW-1:0]    kind;
    logic [PosW-1:0]    pos;
    logic [DataW-1:0]   value;
    logic               typed;
    logic [DataW-1:0]   rd_val;
    logic [StatusW-1:0] status;
    logic [EntCntW-1:0] count;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [ReqW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  // Shadow copy of the list kept by the predictor.
  logic [DataW-1:0]    shadow_vals [ListCap];
  int unsigned         shadow_len;

  list_result_t        pending_results [$];
  int unsigned         error_count;
  int unsigned         src_idle_pct;
  int unsigned         sink_stall_pct;

  // Directed rows: typed expectations only where they are obvious.
  dir_row_t dir_rows [24] = '{
    '{REQ_GET,         8'd0,   32'd0,        1'b1, ValAllOne, ST_RANGE, 9'd0},
    '{REQ_DELETE_AT,   8'd0,   32'd0,        1'b1, 32'd0,     ST_RANGE, 9'd0},
    '{REQ_INSERT_AT,   8'd1,   32'd5,        1'b1, 32'd0,     ST_RANGE, 9'd0},
    '{REQ_INSERT_HEAD, 8'd0,   ValMaxPos,    1'b1, 32'd0,     ST_DONE,  9'd1},
    '{REQ_DELETE_AT,   8'd0,   32'd0,        1'b1, 32'd0,     ST_DONE,  9'd0},
    '{REQ_GET,         8'd0,   32'd0,        1'b1, ValAllOne, ST_RANGE, 9'd0},
    '{REQ_INSERT_TAIL, 8'd0,   ValMinNeg,    1'b1, 32'd0,     ST_DONE,  9'd1},
    '{REQ_INSERT_HEAD, 8'd0,   ValAllOne,    1'b1, 32'd0,     ST_DONE,  9'd2},
    '{REQ_INSERT_AT,   8'd2,   32'd0,        1'b1, 32'd0,     ST_DONE,  9'd3},
    '{REQ_INSERT_AT,   8'd1,   32'h1234_5678, 1'b0, 32'd0,    ST_DONE,  9'd0},
    '{REQ_GET,         8'd0,   32'd0,        1'b0, 32'd0,     ST_DONE,  9'd0},
    '{REQ_GET,         8'd3,   32'd0,        1'b0, 32'd0,     ST_DONE,  9'd0},
    '{REQ_GET,         8'd255, ValAllOne,    1'b1, ValAllOne, ST_RANGE, 9'd4},
    '{ReqSpare5,       8'd255, ValAllOne,    1'b1, 32'd0,     ST_DONE,  9'd4},
    '{ReqSpare7,       8'd0,   ValMinNeg,    1'b1, 32'd0,     ST_DONE,  9'd4},
    '{ReqSpare6,       8'd2,   32'd0,        1'b1, 32'd0,     ST_DONE,  9'd4},
    '{REQ_DELETE_AT,   8'd255, 32'd0,        1'b1, 32'd0,     ST_RANGE, 9'd4},
    '{REQ_DELETE_AT,   8'd3,   32'd0,        1'b0, 32'd0,     ST_DONE,  9'd0},
    '{REQ_DELETE_AT,   8'd0,   32'd0,        1'b0, 32'd0,     ST_DONE,  9'd0},
    '{REQ_GET,         8'd1,   32'd0,        1'b0, 32'd0,     ST_DONE,  9'd0},
    '{REQ_INSERT_AT,   8'd255, 32'd9,        1'b1, 32'd0,     ST_RANGE, 9'd2},
    '{REQ_DELETE_AT,   8'd1,   32'd0,        1'b0, 32'd0,     ST_DONE,  9'd0},
    '{REQ_DELETE_AT,   8'd0,   32'd0,        1'b0, 32'd0,     ST_DONE,  9'd0},
    '{REQ_INSERT_TAIL, 8'd0,   32'hA5A5_5A5A, 1'b0, 32'd0,    ST_DONE,  9'd0}
  };

  indexed_list_engine_core #(
    .CAPACITY(ListCap)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Prints one line per failure and keeps the tally.
  task automatic note_failure(string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Opens a gap at the given position and stores the value there.
  function automatic logic [StatusW-1:0] shadow_insert(int unsigned at, logic [DataW-1:0] v);
    if (at > shadow_len) begin
      return ST_RANGE;
    end
    if (shadow_len >= ListCap) begin
      return ST_FULL;
    end
    for (int unsigned i = shadow_len; i > at; i--) begin
      shadow_vals[i] = shadow_vals[i-1];
    end
    shadow_vals[at] = v;
    shadow_len++;
    return ST_DONE;
  endfunction

  // Removes the entry at the given position and closes the gap.
  function automatic logic [StatusW-1:0] shadow_delete(int unsigned at);
    if (at >= shadow_len) begin
      return ST_RANGE;
    end
    for (int unsigned i = at; i + 1 < shadow_len; i++) begin
      shadow_vals[i] = shadow_vals[i+1];
    end
    shadow_len--;
    return ST_DONE;
  endfunction

  // Applies one request to the shadow list and returns what the block should answer.
  function automatic list_result_t apply_list_request(logic [ReqW-1:0] kind,
                                                      logic [PosW-1:0] pos,
                                                      logic [DataW-1:0] value);
    list_result_t res;
    res.rd_val = '0;
    res.status = ST_DONE;
    case (kind)
      REQ_GET: begin
        if (pos < shadow_len) begin
          res.rd_val = shadow_vals[pos];
        end else begin
          res.rd_val = ValAllOne;
          res.status = ST_RANGE;
        end
      end
      REQ_INSERT_HEAD: res.status = shadow_insert(0, value);
      REQ_INSERT_TAIL: res.status = shadow_insert(shadow_len, value);
      REQ_INSERT_AT:   res.status = shadow_insert(pos, value);
      REQ_DELETE_AT:   res.status = shadow_delete(pos);
      default: ;
    endcase
    res.count = shadow_len[EntCntW-1:0];
    return res;
  endfunction

  // Presents one request, waits for its transaction and records the answer expected.
  task automatic send_request(logic [ReqW-1:0] kind, logic [PosW-1:0] pos,
                              logic [DataW-1:0] value, logic typed,
                              list_result_t typed_res);
    list_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = {$urandom, 8'($urandom)};
      s_axis_tuser  = 3'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {value, pos};
    s_axis_tuser  = kind;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    res = apply_list_request(kind, pos, value);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  // Holds the request stream off until every answer has been returned.
  task automatic pause_until_drained();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Draws a position that is mostly near the live part of the list.
  function automatic logic [PosW-1:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      return PosW'($urandom_range(shadow_len));
    end else if (roll < 75) begin
      return PosW'(shadow_len);
    end else if (roll < 80) begin
      return '1;
    end else if (roll < 85) begin
      return '0;
    end
    return PosW'($urandom_range(255));
  endfunction

  // Draws a value, with the edges of the signed range now and then.
  function automatic logic [DataW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      return $urandom;
    end else if (roll < 80) begin
      case ($urandom_range(3))
        0:       return ValMaxPos;
        1:       return ValMinNeg;
        2:       return ValAllOne;
        default: return '0;
      endcase
    end
    return DataW'($urandom_range(255));
  endfunction

  // Chooses a request kind weighted by the current mood.
  function automatic logic [ReqW-1:0] pick_kind(mood_e mood);
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned del_pct;
    roll    = $urandom_range(99);
    ins_pct = (mood == MOOD_FILL) ? 60 : (mood == MOOD_DRAIN) ? 20 : 35;
    del_pct = (mood == MOOD_FILL) ? 15 : (mood == MOOD_DRAIN) ? 55 : 30;
    if (roll < ins_pct) begin
      case ($urandom_range(2))
        0:       return REQ_INSERT_HEAD;
        1:       return REQ_INSERT_TAIL;
        default: return REQ_INSERT_AT;
      endcase
    end else if (roll < ins_pct + del_pct) begin
      return REQ_DELETE_AT;
    end else if (roll < 95) begin
      return REQ_GET;
    end
    case ($urandom_range(2))
      0:       return ReqSpare5;
      1:       return ReqSpare6;
      default: return ReqSpare7;
    endcase
  endfunction

  // Receiver: stall decision made at each falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Result checker: each transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing expected: data %h status %0d",
                               m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[DataW-1:0] !== want.rd_val) begin
          note_failure($sformatf("read_value %h, expected %h",
                                 m_axis_tdata[DataW-1:0], want.rd_val));
        end
        if (m_axis_tuser !== want.status) begin
          note_failure($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
        end
        if (m_axis_tdata[DataW+EntCntW-1:DataW] !== want.count) begin
          note_failure($sformatf("entry_count %0d, expected %0d",
                                 m_axis_tdata[DataW+EntCntW-1:DataW], want.count));
        end
      end
    end
  end

  // Watchdog for a block that stops answering.
  initial begin
    #30_000_000;
    $display("indexed_list_engine_core verification failed");
    $finish;
  end

  // Main sequence: reset, directed rows, then random phases of idling.
  initial begin
    int unsigned src_pct [NumPhases];
    int unsigned sink_pct [NumPhases];
    int unsigned per_phase;
    int unsigned calm;
    mood_e       mood;
    list_result_t typed_res;
    src_pct        = '{0, 84, 0, 15};
    sink_pct       = '{0, 0, 84, 15};
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    error_count    = 0;
    shadow_len     = 0;
    per_phase      = NumItems / NumPhases;
    mood           = MOOD_FILL;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, no idling on the request side.
    foreach (dir_rows[r]) begin
      typed_res = '{dir_rows[r].rd_val, dir_rows[r].status, dir_rows[r].count};
      send_request(dir_rows[r].kind, dir_rows[r].pos, dir_rows[r].value,
                   dir_rows[r].typed, typed_res);
    end

    // Random part, one phase per idling pattern.
    for (int p = 0; p < NumPhases; p++) begin
      pause_until_drained();
      for (int unsigned n = 0; n < per_phase; n++) begin
        // Quiet stretches with no idling at the start of every hundred items.
        calm           = ((n % 100) < 15) ? 1 : 0;
        src_idle_pct   = calm ? 0 : src_pct[p];
        sink_stall_pct = calm ? 0 : sink_pct[p];
        if (n % 150 == 0 && !(p == 0 && n == 0)) begin
          mood = mood_e'($urandom_range(2));
        end
        if (n == per_phase / 2) begin
          pause_until_drained();
        end
        send_request(pick_kind(mood), pick_position(), pick_value(), 1'b0, '0);
      end
    end

    // Let the last answers come home.
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("indexed_list_engine_core verification clean");
    end else begin
      $display("indexed_list_engine_core verification failed");
    end
    $finish;
  end

endmodule
